// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the decompressor checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset
`define LZD_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication checked in the cycle after the antecedent
`define LZD_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/lzd_pkg.sv
// ----------------------------------------------------------------------------
// lzd_pkg
// Types and constants shared by the LZ77 flag-bit decompressor.
// ----------------------------------------------------------------------------
package lzd_pkg;

  localparam int unsigned WINDOW_DEPTH_DEF = 8192;
  localparam int unsigned LANES            = 4;
  localparam int unsigned QUEUE_DEPTH      = 4;
  localparam int unsigned DIST_W           = 14;
  localparam int unsigned LEN_W            = 9;
  localparam int unsigned CNT_W            = 3;

  localparam logic [DIST_W-1:0] LONG_BASE  = 14'd8192;
  localparam logic [DIST_W-1:0] SHORT_BASE = 14'd256;

  // Decoder phase, one-hot
  typedef enum logic [7:0] {
    PH_FLAG1     = 8'b0000_0001,
    PH_FLAG2     = 8'b0000_0010,
    PH_SHORTBITS = 8'b0000_0100,
    PH_LITERAL   = 8'b0000_1000,
    PH_LONG_LO   = 8'b0001_0000,
    PH_LONG_HI   = 8'b0010_0000,
    PH_LONG_LEN  = 8'b0100_0000,
    PH_SHORT_OFF = 8'b1000_0000
  } phase_t;

  typedef enum logic [1:0] {
    CMD_LIT  = 2'd0,
    CMD_COPY = 2'd1,
    CMD_END  = 2'd2
  } cmd_kind_t;

  // One decoded command passed from front to back
  typedef struct packed {
    cmd_kind_t         kind;
    logic [7:0]        lit;
    logic [DIST_W-1:0] distance;
    logic [LEN_W-1:0]  len;
  } cmd_t;

  // Back-end sequencer, one-hot
  typedef enum logic [3:0] {
    BK_IDLE = 4'b0001,
    BK_RD   = 4'b0010,
    BK_WR   = 4'b0100,
    BK_EMIT = 4'b1000
  } back_state_t;

endpackage

// File: hw/rtl/lzd_ram.sv
// ----------------------------------------------------------------------------
// lzd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lzd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/lzd_front.sv
// ----------------------------------------------------------------------------
// lzd_front
// Parses control bits and data bytes into literal, copy and end commands.
// ----------------------------------------------------------------------------
module lzd_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_fire,
  input  logic [7:0]    in_byte,
  output logic          push,
  output lzd_pkg::cmd_t push_cmd
);

  import lzd_pkg::*;

  phase_t      phase, phase_next;
  logic [7:0]  control_bits, control_bits_next;
  logic [3:0]  bits_left, bits_left_next;
  logic [15:0] pending_word, pending_word_next;
  logic [1:0]  short_length, short_length_next;
  logic        bit_now;
  logic [15:0] word;

  // Decode one byte, then consume control bits until a data byte is due
  always_comb begin
    phase_next        = phase;
    control_bits_next = control_bits;
    bits_left_next    = bits_left;
    pending_word_next = pending_word;
    short_length_next = short_length;
    push              = 1'b0;
    push_cmd          = '{kind: CMD_LIT, lit: in_byte, distance: '0, len: '0};
    word              = {in_byte, pending_word[7:0]};
    bit_now           = 1'b0;
    if (in_fire) begin
      unique case (phase)
        PH_FLAG1, PH_FLAG2, PH_SHORTBITS: begin
          control_bits_next = in_byte;
          bits_left_next    = 4'd8;
        end
        PH_LITERAL: begin
          push       = 1'b1;
          phase_next = PH_FLAG1;
        end
        PH_LONG_LO: begin
          pending_word_next = {8'd0, in_byte};
          phase_next        = PH_LONG_HI;
        end
        PH_LONG_HI: begin
          pending_word_next = word;
          if (word == 16'd0) begin
            push              = 1'b1;
            push_cmd.kind     = CMD_END;
            control_bits_next = 8'd0;
            bits_left_next    = 4'd0;
            phase_next        = PH_FLAG1;
          end else if (word[2:0] == 3'd0) begin
            phase_next = PH_LONG_LEN;
          end else begin
            push              = 1'b1;
            push_cmd.kind     = CMD_COPY;
            push_cmd.distance = LONG_BASE - {1'b0, word[15:3]};
            push_cmd.len      = LEN_W'(word[2:0]) + LEN_W'(2);
            phase_next        = PH_FLAG1;
          end
        end
        PH_LONG_LEN: begin
          push              = 1'b1;
          push_cmd.kind     = CMD_COPY;
          push_cmd.distance = LONG_BASE - {1'b0, pending_word[15:3]};
          push_cmd.len      = LEN_W'(in_byte) + LEN_W'(1);
          phase_next        = PH_FLAG1;
        end
        PH_SHORT_OFF: begin
          push              = 1'b1;
          push_cmd.kind     = CMD_COPY;
          push_cmd.distance = SHORT_BASE - DIST_W'(in_byte);
          push_cmd.len      = LEN_W'(short_length) + LEN_W'(2);
          phase_next        = PH_FLAG1;
        end
        default: begin
          phase_next = PH_FLAG1;
        end
      endcase
      // At most four control bits are taken before a data byte is due
      for (int i = 0; i < 4; i++) begin
        if ((phase_next == PH_FLAG1 || phase_next == PH_FLAG2 ||
             phase_next == PH_SHORTBITS) && bits_left_next != 4'd0) begin
          bit_now           = control_bits_next[0];
          control_bits_next = control_bits_next >> 1;
          bits_left_next    = bits_left_next - 4'd1;
          if (phase_next == PH_FLAG1) begin
            phase_next = bit_now ? PH_LITERAL : PH_FLAG2;
          end else if (phase_next == PH_FLAG2) begin
            if (bit_now) begin
              phase_next = PH_LONG_LO;
            end else begin
              phase_next        = PH_SHORTBITS;
              pending_word_next = 16'd0;
              short_length_next = 2'd0;
            end
          end else begin
            short_length_next = {short_length_next[0], bit_now};
            if (pending_word_next == 16'd0) begin
              pending_word_next = 16'd1;
            end else begin
              phase_next = PH_SHORT_OFF;
            end
          end
        end
      end
    end
  end

  // Hold decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_FLAG1;
      control_bits <= 8'd0;
      bits_left    <= 4'd0;
      pending_word <= 16'd0;
      short_length <= 2'd0;
    end else begin
      phase        <= phase_next;
      control_bits <= control_bits_next;
      bits_left    <= bits_left_next;
      pending_word <= pending_word_next;
      short_length <= short_length_next;
    end
  end

endmodule

// File: hw/rtl/lzd_queue.sv
// ----------------------------------------------------------------------------
// lzd_queue
// Short command queue between the parser and the copy engine.
// ----------------------------------------------------------------------------
module lzd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  lzd_pkg::cmd_t push_cmd,
  input  logic          pop,
  output logic          full,
  output logic          empty,
  output lzd_pkg::cmd_t head
);

  import lzd_pkg::*;

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);

  cmd_t          slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [PW:0]   count;

  assign full  = (count == (PW+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  // Store payload
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + (PW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (PW+1)'(1);
      end
    end
  end

endmodule

// File: hw/rtl/lzd_back.sv
// ----------------------------------------------------------------------------
// lzd_back
// Carries out commands against the history window and packs output bytes.
// ----------------------------------------------------------------------------
module lzd_back #(
  parameter int unsigned WINDOW_DEPTH = lzd_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_empty,
  input  lzd_pkg::cmd_t               q_head,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  out_byte_a,
  output logic [7:0]                  out_byte_b,
  output logic [7:0]                  out_byte_c,
  output logic [7:0]                  out_byte_d,
  output logic [lzd_pkg::CNT_W-1:0]   byte_count,
  output logic                        last_of_run,
  output logic                        stream_end
);

  import lzd_pkg::*;

  localparam int unsigned AW = $clog2(WINDOW_DEPTH);

  back_state_t       state;
  logic [AW-1:0]     write_pointer;
  logic [DIST_W-1:0] copy_dist;
  logic [LEN_W-1:0]  remaining;
  logic [7:0]        lanes [LANES];
  logic [CNT_W-1:0]  fill;
  logic              pack_last, pack_end;
  logic              ram_we;
  logic [7:0]        ram_wdata, ram_rdata;
  logic [AW-1:0]     ram_raddr;
  logic              out_free;

  assign out_free  = !out_valid || !out_stall;
  assign q_pop     = (state == BK_IDLE) && !q_empty;
  assign ram_raddr = write_pointer - AW'(copy_dist);
  assign ram_we    = (q_pop && q_head.kind == CMD_LIT) || (state == BK_WR);
  assign ram_wdata = (state == BK_WR) ? ram_rdata : q_head.lit;

  lzd_ram #(
    .WIDTH (8),
    .DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (write_pointer),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Payload of the current copy and the packing lanes
  always_ff @(posedge clk) begin
    if (q_pop) begin
      copy_dist <= q_head.distance;
      remaining <= q_head.len;
    end
    if (state == BK_WR) begin
      remaining <= remaining - LEN_W'(1);
    end
    if (rst) begin
      for (int i = 0; i < LANES; i++) begin
        lanes[i] <= 8'd0;
      end
    end else begin
      if (q_pop) begin
        lanes[0] <= (q_head.kind == CMD_LIT) ? q_head.lit : 8'd0;
      end
      if (state == BK_WR) begin
        lanes[fill[1:0]] <= ram_rdata;
      end
      if (state == BK_EMIT && out_free) begin
        for (int i = 0; i < LANES; i++) begin
          lanes[i] <= 8'd0;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (state == BK_EMIT && out_free) begin
      out_byte_a  <= lanes[0];
      out_byte_b  <= lanes[1];
      out_byte_c  <= lanes[2];
      out_byte_d  <= lanes[3];
      byte_count  <= fill;
      last_of_run <= pack_last;
      stream_end  <= pack_end;
    end
  end

  // Sequencer: one byte per read and write pair, and an emit step per result
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= BK_IDLE;
      write_pointer <= '0;
      fill          <= '0;
      pack_last     <= 1'b0;
      pack_end      <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (state == BK_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        BK_IDLE: begin
          if (q_pop) begin
            unique case (q_head.kind)
              CMD_LIT: begin
                write_pointer <= write_pointer + AW'(1);
                fill          <= CNT_W'(1);
                pack_last     <= 1'b1;
                pack_end      <= 1'b0;
                state         <= BK_EMIT;
              end
              CMD_END: begin
                fill      <= '0;
                pack_last <= 1'b1;
                pack_end  <= 1'b1;
                state     <= BK_EMIT;
              end
              default: begin
                pack_end <= 1'b0;
                state    <= BK_RD;
              end
            endcase
          end
        end
        BK_RD: begin
          state <= BK_WR;
        end
        BK_WR: begin
          write_pointer <= write_pointer + AW'(1);
          fill          <= fill + CNT_W'(1);
          if (remaining == LEN_W'(1)) begin
            pack_last <= 1'b1;
            state     <= BK_EMIT;
          end else if (fill == CNT_W'(LANES - 1)) begin
            pack_last <= 1'b0;
            state     <= BK_EMIT;
          end else begin
            state <= BK_RD;
          end
        end
        BK_EMIT: begin
          if (out_free) begin
            fill  <= '0;
            state <= pack_last ? BK_IDLE : BK_RD;
          end
        end
        default: begin
          state <= BK_IDLE;
        end
      endcase
    end
  end

endmodule

// File: hw/rtl/lz77_flag_bit_decompressor.sv
// Path: a literal or end result passes the command queue, the emit state and the output
// register after its byte is accepted; a copy's first result also waits for its read/write pairs.
// Throughput: one compressed byte per cycle while the 4-entry command queue has room.
// Copies move each byte by a window read then a write, plus an emit step per result;
// the copy engine pops the next command only from its idle state, so a literal holds it for its emit step.
// Reset clears the parser, queue and pointers; the window is not cleared.
// ----------------------------------------------------------------------------
// lz77_flag_bit_decompressor
// Flag-bit LZ77 stream decoder with a parser front end and a copy engine.
// ----------------------------------------------------------------------------
module lz77_flag_bit_decompressor #(
  parameter int unsigned WINDOW_DEPTH = lzd_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                in_byte,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [7:0]                out_byte_a,
  output logic [7:0]                out_byte_b,
  output logic [7:0]                out_byte_c,
  output logic [7:0]                out_byte_d,
  output logic [lzd_pkg::CNT_W-1:0] byte_count,
  output logic                      last_of_run,
  output logic                      stream_end
);

  import lzd_pkg::*;

  logic in_fire, push, pop, q_full, q_empty;
  cmd_t push_cmd, q_head;

  // Accept while the queue has room
  assign in_stall = q_full;
  assign in_fire  = in_valid && !q_full;

  lzd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .in_byte  (in_byte),
    .push     (push),
    .push_cmd (push_cmd)
  );

  lzd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (q_head)
  );

  lzd_back #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_head      (q_head),
    .q_pop       (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte_a  (out_byte_a),
    .out_byte_b  (out_byte_b),
    .out_byte_c  (out_byte_c),
    .out_byte_d  (out_byte_d),
    .byte_count  (byte_count),
    .last_of_run (last_of_run),
    .stream_end  (stream_end)
  );

endmodule

// File: hw/rtl/lzd_checker.sv
// ----------------------------------------------------------------------------
// lzd_checker
// Port-level checks on the decompressor result stream.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lzd_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] byte_count,
  input logic       last_of_run,
  input logic       stream_end
);

  // A stalled result is held
  `LZD_ASSERT_NXT(a_hold, clk, rst, out_valid && out_stall, out_valid && $stable(byte_count), "stalled result changed")

  // End marker carries no bytes and closes its run
  `LZD_ASSERT_IMP(a_end, clk, rst, out_valid && stream_end, byte_count == 3'd0 && last_of_run, "bad end marker result")

  // Only the final result of a run may be partly filled
  `LZD_ASSERT_IMP(a_full, clk, rst, out_valid && !last_of_run, byte_count == 3'd4, "short result inside a run")

  // Byte count never exceeds the lane count
  `LZD_ASSERT_IMP(a_count, clk, rst, out_valid, byte_count <= 3'd4, "byte count out of range")

endmodule

bind lz77_flag_bit_decompressor lzd_checker u_lzd_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .byte_count  (byte_count),
  .last_of_run (last_of_run),
  .stream_end  (stream_end)
);

// File: test/lz77_flag_bit_decompressor_tb.sv
// ----------------------------------------------------------------------------
// lz77_flag_bit_decompressor_tb
// Encodes directed and random LZ77 flag-bit streams, feeds them with random gaps and
// back-pressure, and checks every output transaction against a local decoder.
// ----------------------------------------------------------------------------
module lz77_flag_bit_decompressor_tb;
  import lzd_pkg::*;

  localparam int WIN       = 8192;
  localparam int CYC_LIMIT = 5000000;

  typedef struct {
    logic [7:0] a, b, c, d;
    logic [2:0] cnt;
    logic       last;
    logic       send;
  } chunk_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte_a, out_byte_b, out_byte_c, out_byte_d;
  logic [CNT_W-1:0] byte_count;
  logic       last_of_run, stream_end;

  lz77_flag_bit_decompressor dut (.*);

  always #5 clk = ~clk;

  // Stream under construction and expected decoded chunks
  logic [7:0] comp_bytes[$];
  chunk_t     chunks_due[$];
  int         flag_slot;
  int         flag_used = 8;
  int         produced  = 0;
  int         mismatches = 0;
  int         cycles = 0;
  bit         calm = 1'b0;

  // Local decoder state
  phase_t      dec_phase = PH_FLAG1;
  logic [7:0]  dec_ctl = 8'd0;
  int          dec_left = 0;
  logic [15:0] dec_word = 16'd0;
  logic [1:0]  dec_slen = 2'd0;
  logic [7:0]  window[WIN];
  logic [12:0] dec_wp = 13'd0;
  logic [7:0]  run_bytes[$];

  // ---------------- encoder ----------------
  task automatic put_flag(input bit f);
    logic [7:0] t;
    if (flag_used == 8) begin
      comp_bytes.push_back(8'($urandom));
      flag_slot = comp_bytes.size() - 1;
      flag_used = 0;
    end
    t = comp_bytes[flag_slot];
    t[flag_used] = f;
    comp_bytes[flag_slot] = t;
    flag_used++;
  endtask

  task automatic enc_literal(input logic [7:0] v);
    put_flag(1'b1);
    comp_bytes.push_back(v);
    produced++;
  endtask

  // len 3..9 uses the plain word when asked; otherwise the extra length byte
  task automatic enc_long(input int offs, input int len, input bit plain);
    logic [15:0] w;
    put_flag(1'b0);
    put_flag(1'b1);
    w = 16'((WIN - offs) << 3);
    if (plain) w[2:0] = 3'(len - 2);
    comp_bytes.push_back(w[7:0]);
    comp_bytes.push_back(w[15:8]);
    if (!plain) comp_bytes.push_back(8'(len - 1));
    produced += len;
  endtask

  task automatic enc_short(input int offs, input int len);
    logic [1:0] l;
    l = 2'(len - 2);
    put_flag(1'b0);
    put_flag(1'b0);
    put_flag(l[1]);
    put_flag(l[0]);
    comp_bytes.push_back(8'(256 - offs));
    produced += len;
  endtask

  task automatic enc_end();
    put_flag(1'b0);
    put_flag(1'b1);
    comp_bytes.push_back(8'd0);
    comp_bytes.push_back(8'd0);
    flag_used = 8;
  endtask

  // ---------------- decoder ----------------
  task automatic emit_byte(input logic [7:0] v);
    window[dec_wp] = v;
    dec_wp++;
    run_bytes.push_back(v);
  endtask

  task automatic copy_from(input int offs, input int len);
    for (int i = 0; i < len; i++) emit_byte(window[13'(dec_wp - 13'(offs))]);
  endtask

  task automatic decode_byte(input logic [7:0] v);
    bit     ended;
    bit     f;
    chunk_t ch;
    int     pos;
    ended = 1'b0;
    run_bytes.delete();
    case (dec_phase)
      PH_FLAG1, PH_FLAG2, PH_SHORTBITS: begin
        dec_ctl  = v;
        dec_left = 8;
      end
      PH_LITERAL: begin
        emit_byte(v);
        dec_phase = PH_FLAG1;
      end
      PH_LONG_LO: begin
        dec_word  = {8'd0, v};
        dec_phase = PH_LONG_HI;
      end
      PH_LONG_HI: begin
        dec_word[15:8] = v;
        if (dec_word == 16'd0) begin
          ended     = 1'b1;
          dec_ctl   = 8'd0;
          dec_left  = 0;
          dec_phase = PH_FLAG1;
        end else if (dec_word[2:0] == 3'd0) begin
          dec_phase = PH_LONG_LEN;
        end else begin
          copy_from(WIN - int'(dec_word[15:3]), int'(dec_word[2:0]) + 2);
          dec_phase = PH_FLAG1;
        end
      end
      PH_LONG_LEN: begin
        copy_from(WIN - int'(dec_word[15:3]), int'(v) + 1);
        dec_phase = PH_FLAG1;
      end
      default: begin
        copy_from(256 - int'(v), int'(dec_slen) + 2);
        dec_phase = PH_FLAG1;
      end
    endcase
    // Consume control bits until a data byte is needed
    while ((dec_phase == PH_FLAG1 || dec_phase == PH_FLAG2 ||
            dec_phase == PH_SHORTBITS) && dec_left > 0) begin
      f = dec_ctl[0];
      dec_ctl = dec_ctl >> 1;
      dec_left--;
      if (dec_phase == PH_FLAG1) begin
        dec_phase = f ? PH_LITERAL : PH_FLAG2;
      end else if (dec_phase == PH_FLAG2) begin
        if (f) begin
          dec_phase = PH_LONG_LO;
        end else begin
          dec_phase = PH_SHORTBITS;
          dec_word  = 16'd0;
          dec_slen  = 2'd0;
        end
      end else begin
        dec_slen = {dec_slen[0], f};
        if (dec_word == 16'd0) dec_word = 16'd1;
        else dec_phase = PH_SHORT_OFF;
      end
    end
    if (ended) begin
      ch = '{8'd0, 8'd0, 8'd0, 8'd0, 3'd0, 1'b1, 1'b1};
      chunks_due.push_back(ch);
    end else begin
      pos = 0;
      while (pos < run_bytes.size()) begin
        ch = '{8'd0, 8'd0, 8'd0, 8'd0, 3'd0, 1'b0, 1'b0};
        ch.cnt = 3'((run_bytes.size() - pos) > 4 ? 4 : (run_bytes.size() - pos));
        ch.a = run_bytes[pos];
        if (ch.cnt > 1) ch.b = run_bytes[pos + 1];
        if (ch.cnt > 2) ch.c = run_bytes[pos + 2];
        if (ch.cnt > 3) ch.d = run_bytes[pos + 3];
        pos += ch.cnt;
        ch.last = (pos == run_bytes.size());
        chunks_due.push_back(ch);
      end
    end
  endtask

  // Mostly no gap, else short gaps, a few long ones, none during calm stretches
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // ---------------- driver ----------------
  int in_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) decode_byte(in_byte);
      if ($urandom_range(0, 49) == 0) calm = ~calm;
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (comp_bytes.size() > 0) begin
        in_byte  <= comp_bytes.pop_front();
        in_valid <= 1'b1;
        in_gap   = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------- receiver stall ----------------
  int stall_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      stall_left = pick_gap();
      out_stall <= (stall_left > 0);
    end
  end

  // ---------------- monitor ----------------
  always @(posedge clk) begin
    chunk_t want;
    cycles++;
    if (cycles > CYC_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else if (!rst && out_valid && !out_stall) begin
      if (chunks_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output transaction");
      end else begin
        want = chunks_due.pop_front();
        if (out_byte_a !== want.a || out_byte_b !== want.b || out_byte_c !== want.c ||
            out_byte_d !== want.d || byte_count !== want.cnt ||
            last_of_run !== want.last || stream_end !== want.send) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %h %h %h %h cnt %0d last %b end %b, got %h %h %h %h cnt %0d last %b end %b",
                     want.a, want.b, want.c, want.d, want.cnt, want.last, want.send,
                     out_byte_a, out_byte_b, out_byte_c, out_byte_d, byte_count,
                     last_of_run, stream_end);
        end
      end
    end
  end

  // ---------------- stimulus ----------------
  initial begin
    int sel, offs, len, cap;
    // Directed: literal extremes, overlapping copies, longest copy, end marker
    enc_literal(8'h00);
    enc_literal(8'hFF);
    enc_literal(8'hA5);
    enc_literal(8'h5A);
    enc_short(1, 5);
    enc_long(1, 256, 1'b0);
    enc_short(256, 2);
    enc_long(4, 1, 1'b0);
    enc_long(produced, 9, 1'b1);
    enc_long(3, 3, 1'b1);
    enc_short(17, 3);
    enc_end();
    // New stream whose copy reaches into the previous one
    enc_literal(8'h3C);
    enc_long(produced, 4, 1'b1);
    enc_short(200, 4);
    enc_end();
    // Random streams, mostly literals and short copies
    while (comp_bytes.size() < 305) begin
      sel = $urandom_range(0, 99);
      cap = produced > WIN - 1 ? WIN - 1 : produced;
      if (sel < 40) begin
        enc_literal(8'($urandom));
      end else if (sel < 65) begin
        offs = $urandom_range(1, cap > 256 ? 256 : cap);
        enc_short(offs, $urandom_range(2, 5));
      end else if (sel < 85) begin
        offs = ($urandom_range(0, 3) == 0) ? cap : $urandom_range(1, cap > 40 ? 40 : cap);
        enc_long(offs, $urandom_range(3, 9), 1'b1);
      end else if (sel < 95) begin
        offs = $urandom_range(1, cap);
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 256) : $urandom_range(1, 16);
        enc_long(offs, len, 1'b0);
      end else begin
        enc_end();
      end
    end
    enc_end();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    // Drain stimulus and expected output, then let the pipeline settle
    wait (comp_bytes.size() == 0 && !in_valid && chunks_due.size() == 0);
    repeat (100) @(posedge clk);
    if (mismatches == 0 && chunks_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/lzd_pkg.sv
hw/rtl/lzd_ram.sv
hw/rtl/lzd_front.sv
hw/rtl/lzd_queue.sv
hw/rtl/lzd_back.sv
hw/rtl/lz77_flag_bit_decompressor.sv
hw/rtl/lzd_checker.sv
test/lz77_flag_bit_decompressor_tb.sv
